// ----- design/qau_pkg.sv -----
`default_nettype none

package qau_pkg;

   // Component format: signed, COMP_W bits with FRAC_BITS fraction bits
   localparam int COMP_W    = 16;
   localparam int FRAC_BITS = 13;

   localparam int NCOMP = 4;
   localparam int NVEC  = 3;
   localparam int IX    = 0;
   localparam int IY    = 1;
   localparam int IZ    = 2;
   localparam int IW    = 3;

   // Internal widths, all exact for the component format
   localparam int PROD_W = 2 * COMP_W;           // one component product
   localparam int ACC_W  = PROD_W + 2;           // sum of four products
   localparam int RND_W  = ACC_W - FRAC_BITS;    // rounded sum
   localparam int SIMP_W = COMP_W + 1;           // add, sub, negate
   localparam int TWO_W  = COMP_W + 1;           // 2*w
   localparam int RP_W   = RND_W + TWO_W;        // cross * 2w
   localparam int QP_W   = COMP_W + RND_W;       // component * cross
   localparam int FIN_W  = QP_W + 3;             // final sum before clamp

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_PROD  = 3'd2,
      OP_SCALE = 3'd3,
      OP_CONJ  = 3'd4,
      OP_DOT   = 3'd5,
      OP_ROT   = 3'd6,
      OP_EQ    = 3'd7
   } opcode_type;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef comp_type quat_type [NCOMP];
   typedef comp_type vec_type [NVEC];
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [RND_W-1:0]  rnd_type;
   typedef logic signed [SIMP_W-1:0] simp_type;
   typedef logic signed [TWO_W-1:0]  two_type;
   typedef logic signed [RP_W-1:0]   rp_type;
   typedef logic signed [QP_W-1:0]   qp_type;
   typedef logic signed [FIN_W-1:0]  fin_type;

   typedef struct packed {
      logic     ovf;
      comp_type val;
   } sat_type;

   localparam comp_type COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
   localparam comp_type COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};
   localparam acc_type  ACC_HALF = acc_type'(1) <<< (FRAC_BITS - 1);
   localparam fin_type  FIN_HALF = fin_type'(1) <<< (FRAC_BITS - 1);

   // Round to nearest, ties toward plus infinity: add half, then floor
   function automatic acc_type rnd_acc(input acc_type v);
      return (v + ACC_HALF) >>> FRAC_BITS;
   endfunction

   function automatic fin_type rnd_fin(input fin_type v);
      return (v + FIN_HALF) >>> FRAC_BITS;
   endfunction

   function automatic sat_type sat_comp(input fin_type v);
      sat_type s;
      if (v > fin_type'(COMP_MAX)) begin
         s.ovf = 1'b1;
         s.val = COMP_MAX;
      end else if (v < fin_type'(COMP_MIN)) begin
         s.ovf = 1'b1;
         s.val = COMP_MIN;
      end else begin
         s.ovf = 1'b0;
         s.val = comp_type'(v);
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ----- design/qau_mult_stage.sv -----
`default_nettype none

module qau_mult_stage (
   input  wire                    clock,
   input  wire                    load,
   input  qau_pkg::opcode_type    op_in,
   input  qau_pkg::quat_type      a_in,
   input  qau_pkg::quat_type      b_in,
   output qau_pkg::opcode_type    op_ff,
   output qau_pkg::prod_type      prod_ff [qau_pkg::NCOMP][qau_pkg::NCOMP],
   output qau_pkg::simp_type      simp_ff [qau_pkg::NCOMP],
   output logic                   eq_ff,
   output qau_pkg::quat_type      a_ff,
   output qau_pkg::quat_type      b_ff
);
   import qau_pkg::*;

   prod_type prod_in [NCOMP][NCOMP];
   simp_type simp_in [NCOMP];
   logic     eq_in;

   // All sixteen cross products of A and B components
   always_comb begin
      for (int i = 0; i < NCOMP; i++) begin
         for (int j = 0; j < NCOMP; j++) begin
            prod_in[i][j] = prod_type'(a_in[i]) * prod_type'(b_in[j]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NCOMP; i++) begin
         case (op_in)
            OP_ADD:  simp_in[i] = simp_type'(a_in[i]) + simp_type'(b_in[i]);
            OP_SUB:  simp_in[i] = simp_type'(a_in[i]) - simp_type'(b_in[i]);
            OP_CONJ: simp_in[i] = (i == IW) ? simp_type'(a_in[i]) : -simp_type'(a_in[i]);
            default: simp_in[i] = '0;
         endcase
      end
   end

   assign eq_in = (a_in[IX] == b_in[IX]) && (a_in[IY] == b_in[IY]) &&
                  (a_in[IZ] == b_in[IZ]) && (a_in[IW] == b_in[IW]);

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff   <= op_in;
         prod_ff <= prod_in;
         simp_ff <= simp_in;
         eq_ff   <= eq_in;
         a_ff    <= a_in;
         b_ff    <= b_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/qau_sum_stage.sv -----
`default_nettype none

module qau_sum_stage (
   input  wire                    clock,
   input  wire                    load,
   input  qau_pkg::opcode_type    op_in,
   input  qau_pkg::prod_type      prod_in [qau_pkg::NCOMP][qau_pkg::NCOMP],
   input  qau_pkg::simp_type      simp_in [qau_pkg::NCOMP],
   input  wire                    eq_in,
   input  qau_pkg::quat_type      a_in,
   input  qau_pkg::quat_type      b_in,
   output qau_pkg::opcode_type    op_ff,
   output qau_pkg::acc_type       acc_ff [qau_pkg::NCOMP],
   output qau_pkg::rnd_type       crs_ff [qau_pkg::NVEC],
   output logic                   eq_ff,
   output qau_pkg::quat_type      a_ff,
   output qau_pkg::quat_type      b_ff
);
   import qau_pkg::*;

   acc_type acc_in [NCOMP];
   rnd_type crs_in [NVEC];

   function automatic acc_type ext(input prod_type v);
      return acc_type'(v);
   endfunction

   always_comb begin
      case (op_in)
         OP_ADD, OP_SUB, OP_CONJ: begin
            for (int i = 0; i < NCOMP; i++) acc_in[i] = acc_type'(simp_in[i]);
         end
         OP_PROD: begin
            acc_in[IX] = ext(prod_in[IW][IX]) + ext(prod_in[IX][IW])
                       + ext(prod_in[IY][IZ]) - ext(prod_in[IZ][IY]);
            acc_in[IY] = ext(prod_in[IW][IY]) - ext(prod_in[IX][IZ])
                       + ext(prod_in[IY][IW]) + ext(prod_in[IZ][IX]);
            acc_in[IZ] = ext(prod_in[IW][IZ]) + ext(prod_in[IX][IY])
                       + ext(prod_in[IZ][IW]) - ext(prod_in[IY][IX]);
            acc_in[IW] = ext(prod_in[IW][IW]) - ext(prod_in[IX][IX])
                       - ext(prod_in[IY][IY]) - ext(prod_in[IZ][IZ]);
         end
         OP_SCALE: begin
            for (int i = 0; i < NCOMP; i++) acc_in[i] = ext(prod_in[i][IW]);
         end
         OP_DOT: begin
            acc_in[IX] = ext(prod_in[IX][IX]) + ext(prod_in[IY][IY])
                       + ext(prod_in[IZ][IZ]) + ext(prod_in[IW][IW]);
            acc_in[IY] = '0;
            acc_in[IZ] = '0;
            acc_in[IW] = '0;
         end
         default: begin
            for (int i = 0; i < NCOMP; i++) acc_in[i] = '0;
         end
      endcase
   end

   // Inner cross product q x v, rounded but not clamped
   always_comb begin
      crs_in[IX] = rnd_type'(rnd_acc(ext(prod_in[IY][IZ]) - ext(prod_in[IZ][IY])));
      crs_in[IY] = rnd_type'(rnd_acc(ext(prod_in[IZ][IX]) - ext(prod_in[IX][IZ])));
      crs_in[IZ] = rnd_type'(rnd_acc(ext(prod_in[IX][IY]) - ext(prod_in[IY][IX])));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff  <= op_in;
         acc_ff <= acc_in;
         crs_ff <= crs_in;
         eq_ff  <= eq_in;
         a_ff   <= a_in;
         b_ff   <= b_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/qau_rot_stage.sv -----
`default_nettype none

module qau_rot_stage (
   input  wire                    clock,
   input  wire                    load,
   input  qau_pkg::opcode_type    op_in,
   input  qau_pkg::acc_type       acc_in [qau_pkg::NCOMP],
   input  qau_pkg::rnd_type       crs_in [qau_pkg::NVEC],
   input  wire                    eq_in,
   input  qau_pkg::quat_type      a_in,
   input  qau_pkg::quat_type      b_in,
   output qau_pkg::opcode_type    op_ff,
   output qau_pkg::rnd_type       val_ff [qau_pkg::NCOMP],
   output qau_pkg::rp_type        p1_ff [qau_pkg::NVEC],
   output qau_pkg::qp_type        qa_ff [qau_pkg::NVEC],
   output qau_pkg::qp_type        qb_ff [qau_pkg::NVEC],
   output logic                   eq_ff,
   output qau_pkg::vec_type       bv_ff
);
   import qau_pkg::*;

   rnd_type val_in [NCOMP];
   rp_type  p1_in [NVEC];
   qp_type  qa_in [NVEC];
   qp_type  qb_in [NVEC];
   vec_type bv_in;
   two_type two_aw;

   always_comb begin
      for (int i = 0; i < NCOMP; i++) begin
         case (op_in)
            OP_PROD, OP_SCALE, OP_DOT: val_in[i] = rnd_type'(rnd_acc(acc_in[i]));
            default:                   val_in[i] = rnd_type'(acc_in[i]);
         endcase
      end
   end

   assign two_aw = two_type'(a_in[IW]) <<< 1;

   // Outer terms of the rotation: 2w(q x v) and q x (q x v)
   always_comb begin
      for (int k = 0; k < NVEC; k++) begin
         p1_in[k] = rp_type'(crs_in[k]) * rp_type'(two_aw);
         bv_in[k] = b_in[k];
      end
      qa_in[IX] = qp_type'(a_in[IY]) * qp_type'(crs_in[IZ]);
      qb_in[IX] = qp_type'(a_in[IZ]) * qp_type'(crs_in[IY]);
      qa_in[IY] = qp_type'(a_in[IZ]) * qp_type'(crs_in[IX]);
      qb_in[IY] = qp_type'(a_in[IX]) * qp_type'(crs_in[IZ]);
      qa_in[IZ] = qp_type'(a_in[IX]) * qp_type'(crs_in[IY]);
      qb_in[IZ] = qp_type'(a_in[IY]) * qp_type'(crs_in[IX]);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff  <= op_in;
         val_ff <= val_in;
         p1_ff  <= p1_in;
         qa_ff  <= qa_in;
         qb_ff  <= qb_in;
         eq_ff  <= eq_in;
         bv_ff  <= bv_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/qau_out_stage.sv -----
`default_nettype none

module qau_out_stage (
   input  wire                    clock,
   input  wire                    load,
   input  qau_pkg::opcode_type    op_in,
   input  qau_pkg::rnd_type       val_in [qau_pkg::NCOMP],
   input  qau_pkg::rp_type        p1_in [qau_pkg::NVEC],
   input  qau_pkg::qp_type        qa_in [qau_pkg::NVEC],
   input  qau_pkg::qp_type        qb_in [qau_pkg::NVEC],
   input  wire                    eq_in,
   input  qau_pkg::vec_type       bv_in,
   output qau_pkg::quat_type      r_ff,
   output logic                   ovf_ff
);
   import qau_pkg::*;

   fin_type  rot_fin [NVEC];
   fin_type  fin [NCOMP];
   sat_type  clamp [NCOMP];
   quat_type r_in;
   logic     ovf_in;

   always_comb begin
      for (int k = 0; k < NVEC; k++) begin
         rot_fin[k] = fin_type'(bv_in[k]) + rnd_fin(fin_type'(p1_in[k]))
                    + rnd_fin((fin_type'(qa_in[k]) - fin_type'(qb_in[k])) <<< 1);
      end
   end

   always_comb begin
      for (int i = 0; i < NCOMP; i++) fin[i] = fin_type'(val_in[i]);
      if (op_in == OP_ROT) begin
         for (int k = 0; k < NVEC; k++) fin[k] = rot_fin[k];
         fin[IW] = '0;
      end
      ovf_in = 1'b0;
      for (int i = 0; i < NCOMP; i++) begin
         clamp[i] = sat_comp(fin[i]);
         r_in[i]  = clamp[i].val;
         ovf_in   = ovf_in | clamp[i].ovf;
      end
      // equality reports a flag, never saturates
      if (op_in == OP_EQ) begin
         r_in[IX] = comp_type'(eq_in);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         r_ff   <= r_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/quaternion_arithmetic_unit.sv -----
// Quaternion ALU, signed fixed point, four register stages.
// An accepted transaction passes the mult, sum, rot and out stage registers before its result is valid.
// Throughput: one transaction per cycle while the result side does not stall.
// A stall on the result side holds the pipeline; empty stages still fill.
// Synchronous reset clears the stage valid bits; data registers are not reset.
`default_nettype none

module quaternion_arithmetic_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [2:0]                           req_opcode,
   input  wire  signed [qau_pkg::COMP_W-1:0]    req_a_x,
   input  wire  signed [qau_pkg::COMP_W-1:0]    req_a_y,
   input  wire  signed [qau_pkg::COMP_W-1:0]    req_a_z,
   input  wire  signed [qau_pkg::COMP_W-1:0]    req_a_w,
   input  wire  signed [qau_pkg::COMP_W-1:0]    req_b_x,
   input  wire  signed [qau_pkg::COMP_W-1:0]    req_b_y,
   input  wire  signed [qau_pkg::COMP_W-1:0]    req_b_z,
   input  wire  signed [qau_pkg::COMP_W-1:0]    req_b_w,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [qau_pkg::COMP_W-1:0]    rsp_r_x,
   output logic signed [qau_pkg::COMP_W-1:0]    rsp_r_y,
   output logic signed [qau_pkg::COMP_W-1:0]    rsp_r_z,
   output logic signed [qau_pkg::COMP_W-1:0]    rsp_r_w,
   output logic                                 rsp_overflow
);
   import qau_pkg::*;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   opcode_type req_op;
   quat_type   req_a, req_b;

   opcode_type s1_op;
   prod_type   s1_prod [NCOMP][NCOMP];
   simp_type   s1_simp [NCOMP];
   logic       s1_eq;
   quat_type   s1_a, s1_b;

   opcode_type s2_op;
   acc_type    s2_acc [NCOMP];
   rnd_type    s2_crs [NVEC];
   logic       s2_eq;
   quat_type   s2_a, s2_b;

   opcode_type s3_op;
   rnd_type    s3_val [NCOMP];
   rp_type     s3_p1 [NVEC];
   qp_type     s3_qa [NVEC];
   qp_type     s3_qb [NVEC];
   logic       s3_eq;
   vec_type    s3_bv;

   quat_type   s4_r;
   logic       s4_ovf;

   always_comb begin
      req_op    = opcode_type'(req_opcode);
      req_a[IX] = req_a_x;
      req_a[IY] = req_a_y;
      req_a[IZ] = req_a_z;
      req_a[IW] = req_a_w;
      req_b[IX] = req_b_x;
      req_b[IY] = req_b_y;
      req_b[IZ] = req_b_z;
      req_b[IW] = req_b_w;
   end

   // A stage advances when it is empty or the next one advances
   assign s4_ready  = !s4_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   qau_mult_stage u_mult (
      .clock   (clock),
      .load    (s1_ready),
      .op_in   (req_op),
      .a_in    (req_a),
      .b_in    (req_b),
      .op_ff   (s1_op),
      .prod_ff (s1_prod),
      .simp_ff (s1_simp),
      .eq_ff   (s1_eq),
      .a_ff    (s1_a),
      .b_ff    (s1_b)
   );

   qau_sum_stage u_sum (
      .clock   (clock),
      .load    (s2_ready),
      .op_in   (s1_op),
      .prod_in (s1_prod),
      .simp_in (s1_simp),
      .eq_in   (s1_eq),
      .a_in    (s1_a),
      .b_in    (s1_b),
      .op_ff   (s2_op),
      .acc_ff  (s2_acc),
      .crs_ff  (s2_crs),
      .eq_ff   (s2_eq),
      .a_ff    (s2_a),
      .b_ff    (s2_b)
   );

   qau_rot_stage u_rot (
      .clock   (clock),
      .load    (s3_ready),
      .op_in   (s2_op),
      .acc_in  (s2_acc),
      .crs_in  (s2_crs),
      .eq_in   (s2_eq),
      .a_in    (s2_a),
      .b_in    (s2_b),
      .op_ff   (s3_op),
      .val_ff  (s3_val),
      .p1_ff   (s3_p1),
      .qa_ff   (s3_qa),
      .qb_ff   (s3_qb),
      .eq_ff   (s3_eq),
      .bv_ff   (s3_bv)
   );

   qau_out_stage u_out (
      .clock   (clock),
      .load    (s4_ready),
      .op_in   (s3_op),
      .val_in  (s3_val),
      .p1_in   (s3_p1),
      .qa_in   (s3_qa),
      .qb_in   (s3_qb),
      .eq_in   (s3_eq),
      .bv_in   (s3_bv),
      .r_ff    (s4_r),
      .ovf_ff  (s4_ovf)
   );

   assign rsp_valid    = s4_valid_ff;
   assign rsp_r_x      = s4_r[IX];
   assign rsp_r_y      = s4_r[IY];
   assign rsp_r_z      = s4_r[IZ];
   assign rsp_r_w      = s4_r[IW];
   assign rsp_overflow = s4_ovf;

   // A free result side never stalls the request side
   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while result side is free");

   // Unstalled transaction reaches the output after four stages
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid)
      else $error("transaction lost in pipeline");

   // Overflow only when some component sits at a clamp limit
   a_ovf_clamped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |->
         (rsp_r_x == COMP_MAX || rsp_r_x == COMP_MIN ||
          rsp_r_y == COMP_MAX || rsp_r_y == COMP_MIN ||
          rsp_r_z == COMP_MAX || rsp_r_z == COMP_MIN ||
          rsp_r_w == COMP_MAX || rsp_r_w == COMP_MIN))
      else $error("overflow without a saturated component");

endmodule

`default_nettype wire

// ----- bench/tb_quaternion_arithmetic_unit.sv -----
`timescale 1ns / 1ps

module tb_quaternion_arithmetic_unit;

   import qau_pkg::*;

   localparam int DIRECTED_ROWS   = 24;
   localparam int RANDOM_ITEMS    = 830;
   localparam int PRESSURE_AT     = 300;
   localparam int PRESSURE_CYCLES = 200;
   localparam int DRAIN_CYCLES    = 12;
   localparam int CYCLE_LIMIT     = 400000;

   localparam comp_type UNIT      = comp_type'(1 <<< FRAC_BITS);
   localparam comp_type TWO_UNIT  = comp_type'(2 <<< FRAC_BITS);
   localparam comp_type HALF_UNIT = comp_type'(1 <<< (FRAC_BITS - 1));
   localparam comp_type NEG_UNIT  = comp_type'(-(1 <<< FRAC_BITS));
   localparam comp_type MAXV      = COMP_MAX;
   localparam comp_type MINV      = COMP_MIN;
   localparam comp_type ZERO      = '0;

   typedef struct packed {
      opcode_type op;
      comp_type   ax, ay, az, aw;
      comp_type   bx, by, bz, bw;
   } quat_request;

   typedef struct packed {
      comp_type rx, ry, rz, rw;
      logic     ovf;
   } quat_result;

   typedef struct packed {
      quat_request req;
      logic        typed;
      quat_result  res;
   } directed_row;

   localparam quat_result NO_RESULT = '0;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_opcode;
   comp_type   req_a_x, req_a_y, req_a_z, req_a_w;
   comp_type   req_b_x, req_b_y, req_b_z, req_b_w;
   logic       rsp_valid;
   logic       rsp_stall;
   comp_type   rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w;
   logic       rsp_overflow;

   quat_result pending_results [$];
   int         mismatch_count = 0;
   int         items_sent = 0;
   int         results_checked = 0;
   int         saturated_count = 0;
   int         op_count [8];
   int         cycle_count = 0;
   bit         sender_quiet = 1'b0;
   bit         receiver_hold = 1'b0;
   bit         pressure_done = 1'b0;

   // Rows with a typed result are read straight off the arithmetic;
   // the rest go through the predictor.
   directed_row directed_table [DIRECTED_ROWS] = '{
      '{'{OP_ADD, MAXV, MINV, ZERO, UNIT, MAXV, MINV, ZERO, UNIT},
        1'b1, '{MAXV, MINV, ZERO, TWO_UNIT, 1'b1}},
      '{'{OP_ADD, UNIT, HALF_UNIT, 1, ZERO, NEG_UNIT, HALF_UNIT, -1, ZERO},
        1'b1, '{ZERO, UNIT, ZERO, ZERO, 1'b0}},
      '{'{OP_SUB, MINV, MAXV, ZERO, UNIT, MAXV, MINV, ZERO, HALF_UNIT},
        1'b1, '{MINV, MAXV, ZERO, HALF_UNIT, 1'b1}},
      '{'{OP_SUB, 100, -100, UNIT, NEG_UNIT, -100, 100, HALF_UNIT, HALF_UNIT},
        1'b0, NO_RESULT},
      '{'{OP_PROD, ZERO, ZERO, ZERO, UNIT, 1234, -567, 890, -4321},
        1'b1, '{1234, -567, 890, -4321, 1'b0}},
      '{'{OP_PROD, UNIT, ZERO, ZERO, ZERO, ZERO, UNIT, ZERO, ZERO},
        1'b1, '{ZERO, ZERO, UNIT, ZERO, 1'b0}},
      '{'{OP_PROD, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV},
        1'b0, NO_RESULT},
      '{'{OP_PROD, MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV},
        1'b0, NO_RESULT},
      '{'{OP_SCALE, MAXV, MINV, 1, -1, MINV, MAXV, 77, UNIT},
        1'b1, '{MAXV, MINV, 1, -1, 1'b0}},
      '{'{OP_SCALE, MINV, MAXV, ZERO, HALF_UNIT, 5, 6, 7, MINV},
        1'b1, '{MAXV, MINV, ZERO, -16384, 1'b1}},
      '{'{OP_SCALE, 1, -1, 3, -3, MAXV, MAXV, MAXV, HALF_UNIT},
        1'b1, '{1, ZERO, 2, -1, 1'b0}},
      '{'{OP_CONJ, MINV, MAXV, 5, MINV, 1, 2, 3, 4},
        1'b1, '{MAXV, -32767, -5, MINV, 1'b1}},
      '{'{OP_CONJ, 1234, -1, ZERO, MAXV, MAXV, MINV, -1, 1},
        1'b0, NO_RESULT},
      '{'{OP_DOT, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV},
        1'b1, '{MAXV, ZERO, ZERO, ZERO, 1'b1}},
      '{'{OP_DOT, ZERO, ZERO, ZERO, UNIT, ZERO, ZERO, ZERO, UNIT},
        1'b1, '{UNIT, ZERO, ZERO, ZERO, 1'b0}},
      '{'{OP_DOT, UNIT, MAXV, -3, HALF_UNIT, NEG_UNIT, MAXV, 7, MINV},
        1'b0, NO_RESULT},
      '{'{OP_ROT, ZERO, ZERO, ZERO, UNIT, 1234, -567, 890, MAXV},
        1'b1, '{1234, -567, 890, ZERO, 1'b0}},
      '{'{OP_ROT, ZERO, ZERO, UNIT, ZERO, UNIT, ZERO, ZERO, MINV},
        1'b0, NO_RESULT},
      '{'{OP_ROT, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV},
        1'b0, NO_RESULT},
      '{'{OP_ROT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV},
        1'b0, NO_RESULT},
      '{'{OP_ROT, HALF_UNIT, -4096, UNIT, MINV, MAXV, MINV, 100, 9},
        1'b0, NO_RESULT},
      '{'{OP_EQ, MINV, MAXV, ZERO, -1, MINV, MAXV, ZERO, -1},
        1'b1, '{1, ZERO, ZERO, ZERO, 1'b0}},
      '{'{OP_EQ, UNIT, HALF_UNIT, -5, 7, UNIT, HALF_UNIT, -5, 6},
        1'b1, '{ZERO, ZERO, ZERO, ZERO, 1'b0}},
      '{'{OP_EQ, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO},
        1'b1, '{1, ZERO, ZERO, ZERO, 1'b0}}
   };

   quaternion_arithmetic_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_a_x      (req_a_x),
      .req_a_y      (req_a_y),
      .req_a_z      (req_a_z),
      .req_a_w      (req_a_w),
      .req_b_x      (req_b_x),
      .req_b_y      (req_b_y),
      .req_b_z      (req_b_z),
      .req_b_w      (req_b_w),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_r_x      (rsp_r_x),
      .rsp_r_y      (rsp_r_y),
      .rsp_r_z      (rsp_r_z),
      .rsp_r_w      (rsp_r_w),
      .rsp_overflow (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Add half, then floor: ties go toward plus infinity
   function automatic longint round_frac(input longint v);
      return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic quat_result compute_quat_result(input quat_request q);
      longint ax, ay, az, aw, bx, by, bz, bw, cx, cy, cz;
      longint hi, lo;
      longint v [4];
      comp_type c [4];
      logic ovf;
      ax = $signed(q.ax); ay = $signed(q.ay); az = $signed(q.az); aw = $signed(q.aw);
      bx = $signed(q.bx); by = $signed(q.by); bz = $signed(q.bz); bw = $signed(q.bw);
      hi = (longint'(1) <<< (COMP_W - 1)) - 1;
      lo = -hi - 1;
      for (int i = 0; i < 4; i++) v[i] = 0;
      case (q.op)
         OP_ADD: begin
            v[0] = ax + bx; v[1] = ay + by; v[2] = az + bz; v[3] = aw + bw;
         end
         OP_SUB: begin
            v[0] = ax - bx; v[1] = ay - by; v[2] = az - bz; v[3] = aw - bw;
         end
         OP_PROD: begin
            v[0] = round_frac(aw * bx + ax * bw + ay * bz - az * by);
            v[1] = round_frac(aw * by - ax * bz + ay * bw + az * bx);
            v[2] = round_frac(aw * bz + ax * by + az * bw - ay * bx);
            v[3] = round_frac(aw * bw - ax * bx - ay * by - az * bz);
         end
         OP_SCALE: begin
            v[0] = round_frac(ax * bw); v[1] = round_frac(ay * bw);
            v[2] = round_frac(az * bw); v[3] = round_frac(aw * bw);
         end
         OP_CONJ: begin
            v[0] = -ax; v[1] = -ay; v[2] = -az; v[3] = aw;
         end
         OP_DOT: begin
            v[0] = round_frac(ax * bx + ay * by + az * bz + aw * bw);
         end
         OP_ROT: begin
            // inner cross product is rounded but kept unclamped
            cx = round_frac(ay * bz - az * by);
            cy = round_frac(az * bx - ax * bz);
            cz = round_frac(ax * by - ay * bx);
            v[0] = bx + round_frac(cx * 2 * aw) + round_frac((ay * cz - az * cy) * 2);
            v[1] = by + round_frac(cy * 2 * aw) + round_frac((az * cx - ax * cz) * 2);
            v[2] = bz + round_frac(cz * 2 * aw) + round_frac((ax * cy - ay * cx) * 2);
         end
         default: begin
            v[0] = (ax == bx && ay == by && az == bz && aw == bw) ? 1 : 0;
         end
      endcase
      ovf = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (v[i] > hi) begin
            ovf = 1'b1;
            v[i] = hi;
         end else if (v[i] < lo) begin
            ovf = 1'b1;
            v[i] = lo;
         end
         c[i] = comp_type'(v[i]);
      end
      return '{c[0], c[1], c[2], c[3], ovf};
   endfunction

   function automatic comp_type random_component();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return comp_type'($urandom);
         4: begin
            case ($urandom_range(0, 6))
               0: return MAXV;
               1: return MINV;
               2: return ZERO;
               3: return comp_type'(-1);
               4: return comp_type'(1);
               5: return UNIT;
               default: return NEG_UNIT;
            endcase
         end
         // mostly within the unit range, as orientations and points are
         default: return comp_type'(int'($urandom_range(0, 2 * UNIT)) - int'(UNIT));
      endcase
   endfunction

   function automatic quat_request random_request();
      quat_request q;
      comp_type flip;
      q.op = opcode_type'($urandom_range(0, 7));
      q.ax = random_component(); q.ay = random_component();
      q.az = random_component(); q.aw = random_component();
      q.bx = random_component(); q.by = random_component();
      q.bz = random_component(); q.bw = random_component();
      // equality needs matching operands to be interesting
      if (q.op == OP_EQ && $urandom_range(0, 2) != 0) begin
         q.bx = q.ax; q.by = q.ay; q.bz = q.az; q.bw = q.aw;
         if ($urandom_range(0, 1) == 1) begin
            flip = comp_type'(1) << $urandom_range(0, COMP_W - 1);
            case ($urandom_range(0, 3))
               0: q.bx = q.bx ^ flip;
               1: q.by = q.by ^ flip;
               2: q.bz = q.bz ^ flip;
               default: q.bw = q.bw ^ flip;
            endcase
         end
      end
      return q;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Enter at a falling edge; leave at the falling edge after the transaction.
   task automatic offer(input quat_request q, input logic typed, input quat_result fixed_res);
      quat_result res;
      req_valid  <= 1'b1;
      req_opcode <= q.op;
      req_a_x <= q.ax; req_a_y <= q.ay; req_a_z <= q.az; req_a_w <= q.aw;
      req_b_x <= q.bx; req_b_y <= q.by; req_b_z <= q.bz; req_b_w <= q.bw;
      do @(posedge clock); while (req_stall !== 1'b0);
      res = typed ? fixed_res : compute_quat_result(q);
      pending_results.push_back(res);
      items_sent++;
      op_count[q.op]++;
      if (res.ovf) saturated_count++;
      @(negedge clock);
   endtask

   task automatic pause_sender();
      int gap;
      gap = pick_gap();
      if (gap != 0 && !sender_quiet && !receiver_hold) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic check_field(input string label, input logic signed [COMP_W-1:0] expected,
                              input logic signed [COMP_W-1:0] actual);
      if (actual !== expected) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, expected, actual);
      end
   endtask

   always @(posedge clock) begin
      quat_result want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with nothing expected, got r=(%0d %0d %0d %0d) ovf=%0b",
                     $time, rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w, rsp_overflow);
         end else begin
            want = pending_results.pop_front();
            check_field("r_x", want.rx, rsp_r_x);
            check_field("r_y", want.ry, rsp_r_y);
            check_field("r_z", want.rz, rsp_r_z);
            check_field("r_w", want.rw, rsp_r_w);
            check_field("overflow", COMP_W'(want.ovf), COMP_W'(rsp_overflow));
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: random stalls, quiet stretches, and one long hold-off
   initial begin
      int mode;
      int hold_count;
      rsp_stall = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (!pressure_done && items_sent >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            receiver_hold = 1'b1;
            rsp_stall <= 1'b1;
            for (hold_count = 0; hold_count < PRESSURE_CYCLES; hold_count++)
               @(negedge clock);
            receiver_hold = 1'b0;
         end else begin
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(20, 80)) @(negedge clock);
            end else if (mode < 5) begin
               rsp_stall <= 1'b1;
               repeat (pick_gap() + 1) @(negedge clock);
            end else begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(1, 6)) @(negedge clock);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_ADD;
      {req_a_x, req_a_y, req_a_z, req_a_w} = '0;
      {req_b_x, req_b_y, req_b_z, req_b_w} = '0;
      for (int i = 0; i < 8; i++) op_count[i] = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         offer(directed_table[row].req, directed_table[row].typed, directed_table[row].res);
         pause_sender();
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
         offer(random_request(), 1'b0, NO_RESULT);
         pause_sender();
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d transactions, checked %0d results, %0d of them saturated.",
               items_sent, results_checked, saturated_count);
      $display("Per opcode: add %0d sub %0d prod %0d scale %0d conj %0d dot %0d rot %0d eq %0d",
               op_count[0], op_count[1], op_count[2], op_count[3],
               op_count[4], op_count[5], op_count[6], op_count[7]);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
